/* src/cqfp_pkg.sv */
// Types and constants shared by the quoted-field CSV parser modules.
// Holds the parse mode and event kind codes, the character constants and the
// event bundle that travels from the front part to the back part.
package cqfp_pkg;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	// most events one input byte can cause
	localparam int unsigned MAX_EVENTS = 3;

	// bundle queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_BEFORE  = 3'd0,
		MODE_FIELD   = 3'd1,
		MODE_QUOTE   = 3'd2,
		MODE_AFTER   = 3'd3,
		MODE_DISCARD = 3'd4
	} parse_mode_t;

	typedef enum logic [1:0] {
		EV_CHAR       = 2'd0,
		EV_FIELD_END  = 2'd1,
		EV_RECORD_END = 2'd2,
		EV_EOF        = 2'd3
	} event_kind_t;

	// Events caused by one input byte. At most one of them is a character,
	// so a single byte slot serves the whole bundle.
	typedef struct packed {
		logic [1:0]                   cnt;
		event_kind_t [MAX_EVENTS-1:0] kind;
		logic [7:0]                   ch;
	} bundle_t;

endpackage

/* src/cqfp_front.sv */
// Front part of the quoted-field CSV parser: takes one byte per transfer,
// runs the parse state machine and hands each byte's events on as a bundle.
// Depends on cqfp_pkg.
module cqfp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        text_byte,
	input  logic              end_of_input,
	output logic              push,
	output cqfp_pkg::bundle_t bundle
);

	cqfp_pkg::parse_mode_t mode_q, mode_d, mode_eff;
	logic                  comma_q, comma_d, comma_eff;
	logic                  has_bytes_q, has_bytes_d;
	logic                  consumed;
	logic                  is_quote, is_comma, is_space, is_newline;

	assign is_quote   = (text_byte == cqfp_pkg::CH_QUOTE);
	assign is_comma   = (text_byte == cqfp_pkg::CH_COMMA);
	assign is_space   = (text_byte == cqfp_pkg::CH_SPACE);
	assign is_newline = (text_byte == cqfp_pkg::CH_NEWLINE);

	// A pending quote is resolved first: a doubled quote is consumed as a
	// literal, anything else closes the field and is then parsed after it.
	assign consumed  = (mode_q == cqfp_pkg::MODE_QUOTE) && is_quote;
	assign mode_eff  = (mode_q == cqfp_pkg::MODE_QUOTE) ? cqfp_pkg::MODE_AFTER : mode_q;
	assign comma_eff = (mode_q == cqfp_pkg::MODE_QUOTE) ? 1'b0 : comma_q;

	// next state
	always_comb begin
		mode_d      = mode_q;
		comma_d     = comma_q;
		has_bytes_d = has_bytes_q;
		if (end_of_input) begin
			mode_d      = cqfp_pkg::MODE_BEFORE;
			comma_d     = 1'b0;
			has_bytes_d = 1'b0;
		end else if (consumed) begin
			mode_d      = cqfp_pkg::MODE_FIELD;
			has_bytes_d = 1'b1;
		end else begin
			has_bytes_d = 1'b1;
			mode_d      = mode_eff;
			comma_d     = comma_eff;
			case (mode_eff)
				cqfp_pkg::MODE_BEFORE: begin
					if (is_quote)
						mode_d = cqfp_pkg::MODE_FIELD;
				end
				cqfp_pkg::MODE_FIELD: begin
					if (is_quote)
						mode_d = cqfp_pkg::MODE_QUOTE;
				end
				cqfp_pkg::MODE_AFTER: begin
					if (is_comma)
						comma_d = 1'b1;
					else if (is_quote)
						mode_d = cqfp_pkg::MODE_FIELD;
					else if (!is_space && !is_newline)
						mode_d = cqfp_pkg::MODE_DISCARD;
				end
				default: begin
				end
			endcase
			// a newline always ends the record, also inside a field or a pending quote
			if (is_newline) begin
				mode_d      = cqfp_pkg::MODE_BEFORE;
				comma_d     = 1'b0;
				has_bytes_d = 1'b0;
			end
		end
	end

	// events of this byte
	always_comb begin
		logic [1:0] n;
		n           = 2'd0;
		bundle.kind = '{default: cqfp_pkg::EV_CHAR};
		bundle.ch   = 8'h00;
		if (end_of_input) begin
			if (mode_q == cqfp_pkg::MODE_FIELD || mode_q == cqfp_pkg::MODE_QUOTE) begin
				bundle.kind[n] = cqfp_pkg::EV_FIELD_END;
				n = n + 2'd1;
			end
			if (mode_q != cqfp_pkg::MODE_BEFORE || has_bytes_q) begin
				bundle.kind[n] = cqfp_pkg::EV_RECORD_END;
				n = n + 2'd1;
			end
			bundle.kind[n] = cqfp_pkg::EV_EOF;
			n = n + 2'd1;
		end else if (consumed) begin
			bundle.kind[n] = cqfp_pkg::EV_CHAR;
			bundle.ch      = cqfp_pkg::CH_QUOTE;
			n = n + 2'd1;
		end else begin
			if (mode_q == cqfp_pkg::MODE_QUOTE) begin
				bundle.kind[n] = cqfp_pkg::EV_FIELD_END;
				n = n + 2'd1;
			end
			case (mode_eff)
				cqfp_pkg::MODE_FIELD: begin
					if (is_newline) begin
						bundle.kind[n] = cqfp_pkg::EV_FIELD_END;
						n = n + 2'd1;
					end else if (!is_quote) begin
						bundle.kind[n] = cqfp_pkg::EV_CHAR;
						bundle.ch      = text_byte;
						n = n + 2'd1;
					end
				end
				cqfp_pkg::MODE_AFTER: begin
					// first comma after a field is the separator, later ones are empty fields
					if (is_comma && comma_eff) begin
						bundle.kind[n] = cqfp_pkg::EV_FIELD_END;
						n = n + 2'd1;
					end
				end
				default: begin
				end
			endcase
			if (is_newline) begin
				bundle.kind[n] = cqfp_pkg::EV_RECORD_END;
				n = n + 2'd1;
			end
		end
		bundle.cnt = n;
	end

	assign push = accept && (bundle.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= cqfp_pkg::MODE_BEFORE;
			comma_q     <= 1'b0;
			has_bytes_q <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_d;
			comma_q     <= comma_d;
			has_bytes_q <= has_bytes_d;
		end
	end

endmodule

/* src/cqfp_queue.sv */
// Short bundle queue between the front and back parts of the CSV parser.
// Register-based FIFO of event bundles. Depends on cqfp_pkg.
module cqfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cqfp_pkg::bundle_t wr_bundle,
	input  logic              pop,
	output cqfp_pkg::bundle_t rd_bundle,
	output logic              full,
	output logic              empty
);

	cqfp_pkg::bundle_t                  mem_q [cqfp_pkg::QUEUE_DEPTH];
	logic [cqfp_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
	logic [cqfp_pkg::QCNT_W-1:0]        cnt_q;

	assign full      = (cnt_q == cqfp_pkg::QCNT_W'(cqfp_pkg::QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);
	assign rd_bundle = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + cqfp_pkg::QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + cqfp_pkg::QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + cqfp_pkg::QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - cqfp_pkg::QCNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("bundle queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("bundle queue underflow");
	a_no_empty_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> wr_bundle.cnt != 2'd0) else $error("empty bundle queued");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cqfp_pkg::QCNT_W'(cqfp_pkg::QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

/* src/cqfp_back.sv */
// Back part of the quoted-field CSV parser: walks head bundle events one
// per cycle, unless stalled, into the output register. Uses cqfp_pkg.
module cqfp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  cqfp_pkg::bundle_t head,
	output logic              pop,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,
	output logic [1:0]        m_axis_tuser,
	output logic              m_axis_tlast
);

	logic [1:0]            idx_q;
	logic                  load;
	logic                  is_last;
	cqfp_pkg::event_kind_t kind;
	logic                  valid_q;
	logic [7:0]            data_q;
	logic [1:0]            user_q;
	logic                  last_q;

	assign kind    = head.kind[idx_q];
	assign is_last = (idx_q == head.cnt - 2'd1);
	assign load    = !q_empty && (!valid_q || m_axis_tready);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (m_axis_tready)
				valid_q <= 1'b0;
			if (load)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= (kind == cqfp_pkg::EV_CHAR) ? head.ch : 8'h00;
			user_q <= kind;
			last_q <= is_last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;
	assign m_axis_tlast  = last_q;

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> idx_q < head.cnt) else $error("event index past bundle");
	a_idx_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 2'd0) else $error("event index not rewound after pop");
	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(load && is_last) |=> (m_axis_tvalid && m_axis_tlast)) else $error("last event lost");

endmodule

/* src/csv_quoted_field_parser_top.sv */
// Quoted-field CSV parser, top level.
// Instantiates cqfp_front, cqfp_queue and cqfp_back; depends on cqfp_pkg.
//
// Input channel s_axis: one text byte per transfer in tdata; tuser high marks
// end of input instead of a byte (tdata is then ignored).
// Output channel m_axis: one event per transfer. tuser is the event kind
// (field character, field end, record end, end of input), tdata the field
// character for character events and zero otherwise, tlast marks the final
// event caused by one input transfer. A byte that causes no event gives none.
// Each taken byte's events pass from the front state machine into the
// bundle queue, then one by one into the output register.
// Throughput: one byte per cycle while the receiver is ready and each byte
// causes at most one event; a byte with more (up to three) holds the back
// part until all are sent, and the four-entry queue absorbs that until full.
// When the receiver stalls, the output register holds its event and the
// queue fills; s_axis_tready drops only once the queue is full.
// Reset clears the parse state to record start and empties the queue.
module csv_quoted_field_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] text_byte
	input  logic       s_axis_tuser,  // [0] end_of_input
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] field_byte
	output logic [1:0] m_axis_tuser,  // [1:0] event_kind
	output logic       m_axis_tlast
);

	logic              accept;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	cqfp_pkg::bundle_t wr_bundle;
	cqfp_pkg::bundle_t head;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	cqfp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.text_byte    (s_axis_tdata),
		.end_of_input (s_axis_tuser),
		.push         (push),
		.bundle       (wr_bundle)
	);

	cqfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_bundle (wr_bundle),
		.pop       (pop),
		.rd_bundle (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	cqfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
